// File: design/gbs_pkg.sv
// shared types and constants for the greedy box suppression block
package gbs_pkg;
  localparam int CoordW = 16;
  localparam int AreaW  = 32;
  localparam int ThrW   = 8;
  localparam logic [ThrW-1:0] ThrReset = 8'd154;

  typedef struct packed {
    logic [CoordW-1:0] height;
    logic [CoordW-1:0] width;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] left;
  } box_t;

  typedef enum logic [1:0] {
    VERDICT_SUPPRESSED = 2'd0,
    VERDICT_STORED     = 2'd1,
    VERDICT_FULL       = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  // candidate traveling along the cell row
  typedef struct packed {
    logic              valid;
    logic              hit;
    box_t              box;
    logic [AreaW-1:0]  area;
  } probe_t;
endpackage

// File: design/gbs_cell.sv
// one store cell: holds a kept box and tests the passing candidate against it
module gbs_cell
  import gbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             load,
  input  logic [ThrW-1:0]  thr,
  input  probe_t           probe_in,
  output probe_t           probe_out
);
  box_t             kbox;
  logic [AreaW-1:0] karea;
  logic             kvalid;

  // stage 1 regs
  probe_t           p1;
  logic [CoordW:0]  iw, ih;
  logic             ovl;
  logic [AreaW:0]   asum;
  // stage 2 regs
  probe_t           p2;
  logic [AreaW-1:0] inter;
  logic [AreaW:0]   asum2;
  logic             ovl2;
  // stage 3
  logic [AreaW:0]   uni;
  logic [AreaW:0]   uni_r;
  logic [AreaW-1:0] inter3;
  logic             ovl3;
  probe_t           p3;
  logic [AreaW+ThrW:0] rhs;

  logic [CoordW:0] r0, r1, b0, b1, lx, ly, hx, hy;

  always_comb begin
    r0 = {1'b0, probe_in.box.left} + {1'b0, probe_in.box.width};
    r1 = {1'b0, kbox.left} + {1'b0, kbox.width};
    b0 = {1'b0, probe_in.box.top} + {1'b0, probe_in.box.height};
    b1 = {1'b0, kbox.top} + {1'b0, kbox.height};
    lx = (probe_in.box.left > kbox.left) ? {1'b0, probe_in.box.left} : {1'b0, kbox.left};
    ly = (probe_in.box.top > kbox.top) ? {1'b0, probe_in.box.top} : {1'b0, kbox.top};
    hx = (r0 < r1) ? r0 : r1;
    hy = (b0 < b1) ? b0 : b1;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      kvalid <= 1'b0;
    end else if (load) begin
      kvalid <= 1'b1;
    end
    if (load) begin
      kbox  <= probe_in.box;
      karea <= probe_in.area;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1.valid <= 1'b0;
      p2.valid <= 1'b0;
      p3.valid <= 1'b0;
    end else begin
      p1 <= probe_in;
      p2 <= p1;
      p3 <= p2;
    end
    ovl  <= kvalid && probe_in.valid && (hx > lx) && (hy > ly);
    iw   <= hx - lx;
    ih   <= hy - ly;
    asum <= {1'b0, probe_in.area} + {1'b0, karea};
    inter <= AreaW'(iw[CoordW-1:0]) * AreaW'(ih[CoordW-1:0]);
    asum2 <= asum;
    ovl2  <= ovl;
    uni_r  <= uni;
    inter3 <= inter;
    ovl3   <= ovl2;
  end

  // intersection fits 32 bits since both sides are at most 16 bit extents
  assign uni = asum2 - {1'b0, inter};
  assign rhs = (AreaW+ThrW+1)'(thr) * (AreaW+ThrW+1)'(uni_r);

  always_comb begin
    probe_out = p3;
    if (ovl3 && uni_r != '0 &&
        ({1'b0, inter3, 8'd0} > rhs)) begin
      probe_out.hit = 1'b1;
    end
  end
endmodule

// File: design/greedy_box_suppression.sv
// top level: greedy iou suppression over a row of store cells
// flow: an accepted word walks through the cell row, three register stages
// per cell, then passes drain and out; no new word is taken until the
// result has been accepted and the block is back in idle
// reset (rst, synchronous): store empty, counters zero, threshold 154
module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT       = 64,
  parameter int MAX_CANDIDATES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // box_left, box_top, box_width, box_height
  input  logic [63:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // verdict, candidate_number, kept_total, zero fill
  output logic [23:0] m_tdata,
  output logic        m_tlast
);
  localparam int KW = $clog2(MAX_KEPT + 1);
  localparam int CW = $clog2(MAX_CANDIDATES);
  localparam int DepthLat = 3 * MAX_KEPT;
  localparam int TW = $clog2(DepthLat + 2);

  state_t state, state_next;
  logic [ThrW-1:0] thr;
  logic [KW-1:0] kept_count;
  logic [CW-1:0] cand;
  logic [TW-1:0] timer;
  logic last_r;
  box_t box_r;
  logic [AreaW-1:0] area_r;
  logic [1:0] verdict;
  logic [6:0] kept_total;

  // probe chain between cells
  probe_t chain [MAX_KEPT+1];
  logic [MAX_KEPT-1:0] load_vec;
  logic clear_store;
  logic hit_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ThrReset;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // capture the incoming word and its area (one 16x16 multiply)
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      box_r  <= s_tdata;
      area_r <= AreaW'(s_tdata[47:32]) * AreaW'(s_tdata[63:48]);
      last_r <= s_tlast;
    end
  end

  always_comb begin
    chain[0].valid = (state == ST_SCAN) && (timer == '0);
    chain[0].hit   = 1'b0;
    chain[0].box   = box_r;
    chain[0].area  = area_r;
  end

  for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
    gbs_cell u_cell (
      .clk(clk), .rst(rst), .clear(clear_store), .load(load_vec[g]),
      .thr(thr), .probe_in(g == 0 ? chain[0] : chain[g]),
      .probe_out(chain[g+1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_SCAN;
      ST_SCAN:  if (chain[MAX_KEPT].valid) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_OUT;
      ST_OUT:   if (m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = (state == ST_OUT);
  end

  // loads into cells happen in drain, with the captured box routed to chain[0]
  // cells load from probe_in, which in drain holds the captured box
  logic store_ok;
  assign store_ok = (state == ST_DRAIN) && !hit_r && (kept_count < KW'(MAX_KEPT));
  for (genvar g = 0; g < MAX_KEPT; g++) begin : g_load
    assign load_vec[g] = store_ok && (kept_count == KW'(g));
  end

  assign clear_store = (state == ST_OUT) && m_tready && last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      kept_count <= '0;
      cand <= '0;
      timer <= '0;
      hit_r <= 1'b0;
      verdict <= VERDICT_SUPPRESSED;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) timer <= '0;
      else if (state == ST_SCAN) timer <= timer + 1'b1;
      if (state == ST_SCAN && chain[MAX_KEPT].valid) hit_r <= chain[MAX_KEPT].hit;
      if (state == ST_DRAIN) begin
        if (hit_r) verdict <= VERDICT_SUPPRESSED;
        else if (kept_count < KW'(MAX_KEPT)) begin
          verdict <= VERDICT_STORED;
          kept_count <= kept_count + 1'b1;
        end else verdict <= VERDICT_FULL;
      end
      if (state == ST_OUT && m_tready) begin
        if (last_r) begin
          kept_count <= '0;
          cand <= '0;
        end else begin
          cand <= (cand == CW'(MAX_CANDIDATES - 1)) ? '0 : cand + 1'b1;
        end
      end
    end
  end

  assign kept_total = 7'(kept_count);
  assign m_tdata = {3'd0, kept_total, 12'(cand), verdict};
  assign m_tlast = last_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    kept_count <= KW'(MAX_KEPT)) else $error("kept count overflow");
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result changed");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_tready) else $error("accept while busy");
`endif
endmodule
